>>> src/mpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // queue size fixes the width of the count field
    localparam int unsigned QueueDepth = 16;
    localparam int unsigned CountW     = $clog2(QueueDepth + 1);

    typedef struct packed {
        t_action            action;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        t_status             status;
        logic signed [31:0]  removed_value;
        logic [CountW-1:0]   count;
    } t_out;

    // per-transaction control broadcast to every cell
    typedef struct packed {
        logic               ins;
        logic               del;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

>>> src/mpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain. Cells hold values in descending order from
// cell 0; an insert pushes smaller values one cell down, a delete pulls the
// whole chain one cell up.
// ----------------------------------------------------------------------------
module mpq_cell (
    input  logic                      i_clk,
    input  mpq_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_occupied,
    input  logic                      i_prev_lt,
    input  logic signed [31:0]        i_prev_value,
    input  logic signed [31:0]        i_next_value,
    output logic                      o_lt,
    output logic signed [31:0]        o_value
);
    import mpq_pkg::*;

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    // empty cells count as smaller than anything
    assign o_lt = !i_occupied || (r_value < i_ctl.value);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && o_lt) begin
            n_value = i_prev_lt ? i_prev_value : i_ctl.value;
        end else if (i_ctl.del) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

>>> src/max_priority_queue.sv
`timescale 1ns / 1ps
// An accepted transaction's result is written to the output register at the next clock edge.
// Throughput: one transaction per cycle while o_stall is low; every cell of the chain
// compares in parallel, so an insert or delete finishes in the cycle it is accepted.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// cell contents are not cleared, the entry count alone marks what is held.
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded sorted store of signed values with insert and delete-max, built as
// a chain of compare-and-shift cells with a registered result stage.
// ----------------------------------------------------------------------------
module max_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mpq_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output mpq_pkg::t_out o_data,
    input  logic          i_stall
);
    import mpq_pkg::*;

    localparam int unsigned CW = $clog2(QueueDepth + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_valid;
    t_out               r_out;
    t_out               n_out;
    t_cell_ctl          w_ctl;
    logic               w_in_acc;
    logic               w_full;
    logic               w_empty;
    logic signed [31:0] w_value [QueueDepth];
    logic               w_lt    [QueueDepth];

    assign o_stall  = r_valid && i_stall;
    assign w_in_acc = i_valid && !o_stall;
    assign w_full   = (r_count == CW'(QueueDepth));
    assign w_empty  = (r_count == '0);

    assign w_ctl.ins   = w_in_acc && (i_data.action == ACT_INSERT) && !w_full;
    assign w_ctl.del   = w_in_acc && (i_data.action == ACT_DELETE) && !w_empty;
    assign w_ctl.value = i_data.value;

    genvar g;
    generate
        for (g = 0; g < QueueDepth; g++) begin : g_cell
            logic               w_prev_lt;
            logic signed [31:0] w_prev_value;
            logic signed [31:0] w_next_value;

            if (g == 0) begin : g_head
                assign w_prev_lt    = 1'b0;
                assign w_prev_value = i_data.value;
            end else begin : g_body
                assign w_prev_lt    = w_lt[g-1];
                assign w_prev_value = w_value[g-1];
            end

            if (g == QueueDepth - 1) begin : g_tail
                assign w_next_value = '0;
            end else begin : g_link
                assign w_next_value = w_value[g+1];
            end

            mpq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occupied   (CW'(g) < r_count),
                .i_prev_lt    (w_prev_lt),
                .i_prev_value (w_prev_value),
                .i_next_value (w_next_value),
                .o_lt         (w_lt[g]),
                .o_value      (w_value[g])
            );
        end
    endgenerate

    always_comb begin
        n_count             = r_count;
        n_out.status        = ST_DONE;
        n_out.removed_value = '0;
        if (i_data.action == ACT_INSERT) begin
            if (w_full) begin
                n_out.status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_out.status = ST_EMPTY;
            end else begin
                n_count             = r_count - 1'b1;
                n_out.removed_value = w_value[0];
            end
        end
        n_out.count = CountW'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

>>> src/mpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks for the max priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          o_stall,
    input  logic          o_valid,
    input  mpq_pkg::t_out o_data,
    input  logic          i_stall
);
    import mpq_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // every accepted transaction yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted transaction produced no result");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_FULL |->
            o_data.count == CountW'(QueueDepth) && o_data.removed_value == '0)
        else $error("full status with wrong count or value");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_EMPTY |->
            o_data.count == '0 && o_data.removed_value == '0)
        else $error("empty status with wrong count or value");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
